// ===== sv/ukmmq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ukmmq_pkg
// Opcodes, status codes and fixed widths shared by the min/max queue files.
// ----------------------------------------------------------------------------
package ukmmq_pkg;

  localparam int OP_W  = 2;
  localparam int ST_W  = 3;
  localparam int SUM_W = 28;

  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_MIN = 2'd2;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

endpackage
`default_nettype wire

// ===== sv/ukmmq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ukmmq_if
// Valid/ready channels of the min/max queue: request beats and result beats.
// ----------------------------------------------------------------------------
interface ukmmq_req_if
  import ukmmq_pkg::*;
#(
  parameter int KEY_BITS    = 20,
  parameter int WEIGHT_BITS = 20
);
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        opcode;
  logic [KEY_BITS-1:0]    key;
  logic [WEIGHT_BITS-1:0] weight;

  modport source (output valid, output opcode, output key, output weight, input ready);
  modport sink   (input valid, input opcode, input key, input weight, output ready);
endinterface

interface ukmmq_rsp_if
  import ukmmq_pkg::*;
#(
  parameter int KEY_BITS    = 20,
  parameter int WEIGHT_BITS = 20,
  parameter int COUNT_BITS  = 9
);
  logic                   valid;
  logic                   ready;
  logic [ST_W-1:0]        status;
  logic [KEY_BITS-1:0]    removed_key;
  logic [WEIGHT_BITS-1:0] removed_weight;
  logic [COUNT_BITS-1:0]  entry_count;
  logic [SUM_W-1:0]       weight_total;
  logic [SUM_W-1:0]       key_total;

  modport source (output valid, output status, output removed_key, output removed_weight,
                  output entry_count, output weight_total, output key_total, input ready);
  modport sink   (input valid, input status, input removed_key, input removed_weight,
                  input entry_count, input weight_total, input key_total, output ready);
endinterface
`default_nettype wire

// ===== sv/unique_key_min_max_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unique_key_min_max_queue
// Ordered set of unique keys with weights; insert, remove largest, remove
// smallest, with running key and weight sums and one result beat per request.
//
// Entries live in one RAM as a ring, sorted ascending from a head pointer, so
// removing the smallest entry only advances the head and removing the largest
// only drops the count. One request is worked at a time. A removal reads the
// smallest or largest entry from the RAM, takes the read data, then completes;
// an unused opcode or a removal from an empty store goes straight to
// completion. An insert binary searches the ring, each probe a RAM read, then
// a compare, up to ceil(log2(n+1)) probes for n entries held. A duplicate or a
// dropped insert then completes. A new key shifts the entries above the
// insertion point pos up one slot at one entry per cycle through the single
// read and write port, then writes the new entry. A finished result waits in
// the completion state while the output register is busy. The next request is
// accepted while a finished result still waits on the output register.
// ----------------------------------------------------------------------------
module unique_key_min_max_queue
  import ukmmq_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_BITS    = 20,
  parameter int WEIGHT_BITS = 20
) (
  input wire logic clk,
  input wire logic rst,
  ukmmq_req_if.sink   req,
  ukmmq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DW    = KEY_BITS + WEIGHT_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH     = 3'd1;
  localparam logic [2:0] S_SCMP     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_RMV_RD   = 3'd4;
  localparam logic [2:0] S_RMV_WAIT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  // Ring position of logical slot l.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [2:0]             state;
  logic [OP_W-1:0]        op;
  logic [KEY_BITS-1:0]    key;
  logic [WEIGHT_BITS-1:0] weight;
  logic [IDX_W-1:0]       head;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum_keys;
  logic [SUM_W-1:0]       sum_weights;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [CNT_W-1:0]       mid;
  logic                   dup;
  logic [CNT_W-1:0]       cur;
  logic                   shift_wr;
  logic [IDX_W-1:0]       shift_waddr;
  logic [ST_W-1:0]        res_status;
  logic [KEY_BITS-1:0]    res_key;
  logic [WEIGHT_BITS-1:0] res_weight;

  logic                   out_valid;
  logic [ST_W-1:0]        out_status;
  logic [KEY_BITS-1:0]    out_key;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic [CNT_W-1:0]       out_count;
  logic [SUM_W-1:0]       out_wsum;
  logic [SUM_W-1:0]       out_ksum;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [DW-1:0]          ram_rdata;
  logic [KEY_BITS-1:0]    rd_key;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [CNT_W-1:0]       mid_c;
  logic [CNT_W-1:0]       span;

  assign rd_key    = ram_rdata[DW-1:WEIGHT_BITS];
  assign rd_weight = ram_rdata[WEIGHT_BITS-1:0];
  assign span      = hi - lo;
  assign mid_c     = lo + (span >> 1);

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.removed_key    = out_key;
  assign rsp.removed_weight = out_weight;
  assign rsp.entry_count    = out_count;
  assign rsp.weight_total   = out_wsum;
  assign rsp.key_total      = out_ksum;

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state)
      S_SRCH: begin
        ram_raddr = phys(head, mid_c);
      end
      S_SHIFT: begin
        ram_raddr = phys(head, cur - 1'b1);
        if (shift_wr) begin
          ram_we    = 1'b1;
          ram_waddr = shift_waddr;
          ram_wdata = ram_rdata;
        end else if (cur == lo) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head, lo);
          ram_wdata = {key, weight};
        end
      end
      S_RMV_RD: begin
        if (op == OP_REMOVE_MAX) begin
          ram_raddr = phys(head, count - 1'b1);
        end else begin
          ram_raddr = head;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  ukmmq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      count       <= '0;
      sum_keys    <= '0;
      sum_weights <= '0;
      shift_wr    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // The completion state reloads the output register itself.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.opcode;
            key    <= req.key;
            weight <= req.weight;
            res_key    <= '0;
            res_weight <= '0;
            res_status <= ST_EMPTY;
            lo     <= '0;
            hi     <= count;
            dup    <= 1'b0;
            if (req.opcode == OP_INSERT) begin
              state <= S_SRCH;
            end else if ((req.opcode == OP_REMOVE_MAX || req.opcode == OP_REMOVE_MIN)
                         && count != '0) begin
              state <= S_RMV_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_SCMP;
          end else if (dup) begin
            res_status <= ST_DUPLICATE;
            state      <= S_DONE;
          end else if (count == CNT_W'(CAPACITY)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            cur      <= count;
            shift_wr <= 1'b0;
            state    <= S_SHIFT;
          end
        end
        S_SCMP: begin
          if (rd_key == key) begin
            dup <= 1'b1;
          end
          if (rd_key < key) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_SHIFT: begin
          // Move entries above the insertion point up one slot, top first.
          if (cur > lo) begin
            shift_wr    <= 1'b1;
            shift_waddr <= phys(head, cur);
            cur         <= cur - 1'b1;
          end else if (shift_wr) begin
            shift_wr <= 1'b0;
          end else begin
            count       <= count + 1'b1;
            sum_keys    <= sum_keys + SUM_W'(key);
            sum_weights <= sum_weights + SUM_W'(weight);
            res_status  <= ST_INSERTED;
            state       <= S_DONE;
          end
        end
        S_RMV_RD: begin
          state <= S_RMV_WAIT;
        end
        S_RMV_WAIT: begin
          res_key     <= rd_key;
          res_weight  <= rd_weight;
          res_status  <= ST_REMOVED;
          count       <= count - 1'b1;
          sum_keys    <= sum_keys - SUM_W'(rd_key);
          sum_weights <= sum_weights - SUM_W'(rd_weight);
          if (op == OP_REMOVE_MIN) begin
            if (head == IDX_W'(CAPACITY - 1)) begin
              head <= '0;
            end else begin
              head <= head + 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_key    <= res_key;
            out_weight <= res_weight;
            out_count  <= count;
            out_wsum   <= sum_weights;
            out_ksum   <= sum_keys;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= IDX_W'(CAPACITY - 1))
    else $error("head pointer out of range");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_SCMP) |-> (lo <= hi && hi <= count))
    else $error("search window out of range");

  a_shift_cursor: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (cur >= lo && cur <= count))
    else $error("shift cursor out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");
`endif

endmodule
`default_nettype wire

// ===== sv/ukmmq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ukmmq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ukmmq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
